>>> sv/bounded_fifo_with_search_assert.svh
// assertion macros for the bounded fifo with search block
`ifndef BOUNDED_FIFO_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_FIFO_WITH_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define BFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define BFS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BFS_ASSERT(lbl, prop, msg)
`define BFS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

>>> sv/bfs_pkg.sv
// shared types, constants and helpers of the bounded fifo with search block
package bfs_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // register index taken from the word address
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

    typedef logic [1:0] t_action;
    localparam t_action ACT_ENQ     = 2'd0;
    localparam t_action ACT_DEQ     = 2'd1;
    localparam t_action ACT_QUERY   = 2'd2;
    localparam t_action ACT_DISPLAY = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_ENQ      = 3'd0;
    localparam t_status ST_OVF      = 3'd1;
    localparam t_status ST_DEQ      = 3'd2;
    localparam t_status ST_UNF      = 3'd3;
    localparam t_status ST_FOUND    = 3'd4;
    localparam t_status ST_NOTFOUND = 3'd5;
    localparam t_status ST_ENTRY    = 3'd6;
    localparam t_status ST_EMPTY    = 3'd7;

    // source of the result data word
    typedef logic [1:0] t_dsel;
    localparam t_dsel DSEL_ZERO  = 2'd0;
    localparam t_dsel DSEL_VALUE = 2'd1;
    localparam t_dsel DSEL_RDATA = 2'd2;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        logic    walk_inc;
        logic    cmp_en;
        logic    enq_do;
        logic    deq_do;
        logic    out_load;
        t_status out_status;
        t_dsel   out_dsel;
        logic    out_last;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    empty;
        logic    full;
        logic    walk_end;
        logic    out_free;
        logic    hit;
    } t_stat;

    // ring slot at a given offset from the head
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

>>> sv/bfs_if.sv
// item channel interfaces of the bounded fifo with search block
interface bfs_in_if;
    logic                        valid;
    logic                        ready;
    bfs_pkg::t_action            action;
    logic signed [bfs_pkg::DATA_W-1:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface bfs_out_if;
    logic                        valid;
    logic                        ready;
    bfs_pkg::t_status            status;
    logic signed [bfs_pkg::DATA_W-1:0] data;
    logic                        last;

    modport source (output valid, status, data, last, input ready);
    modport sink   (input valid, status, data, last, output ready);
endinterface

>>> sv/bounded_fifo_with_search.sv
// top level of the bounded fifo with search block
// A bounded queue of signed 32-bit values in a 16-entry ring store with one write
// and one registered read port; the capacity register (byte address 0, reset 16,
// values above the depth saturate, zero means always full) limits how many are held.
// One item is taken at a time. A query walks the store through its single read port,
// one entry per cycle; a display walks it the same way and gives count results, one a
// cycle while the output drains. Results sit in an output register, so the next item
// is taken while the last result still waits. No clearing pass after reset: only
// written entries are ever read.
`include "bounded_fifo_with_search_assert.svh"

module bounded_fifo_with_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bfs_in_if.sink                       i_in,
    bfs_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [bfs_pkg::PDATA_W-1:0]  pwdata,
    output logic [bfs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // command and status between sequencer and datapath
    bfs_pkg::t_cmd  w_cmd;
    bfs_pkg::t_stat w_stat;
    logic           w_in_ready;
    logic           w_cfg_we;

    // apb write lands in the access phase, never waits
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    bfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bfs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_action     (i_in.action),
        .i_value      (i_in.value),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_status (o_out.status),
        .o_out_data   (o_out.data),
        .o_out_last   (o_out.last),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_addr   (paddr),
        .i_cfg_wdata  (pwdata),
        .o_cfg_rdata  (prdata)
    );

    // input side is ready only while no item is in flight
    assign i_in.ready = w_in_ready;

    // no store write past the capacity, no pop from an empty queue
    `BFS_ASSERT(a_enq_not_full, !w_cmd.enq_do || !w_stat.full, "enqueue write while full")
    `BFS_ASSERT(a_deq_not_empty, !w_cmd.deq_do || !w_stat.empty, "dequeue while empty")
    // a waiting result is never overwritten
    `BFS_ASSERT(a_out_no_clobber, !w_cmd.out_load || w_stat.out_free, "result overwritten")
    // one item at a time: after an accept the input side closes
    `BFS_ASSERT_NEXT(a_one_item, i_in.valid && i_in.ready, !i_in.ready, "second item taken")

endmodule

>>> sv/bfs_ram.sv
// generic single write port ram with registered read
module bfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bfs_ctrl.sv
// sequencer of the bounded fifo with search block
module bfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bfs_pkg::t_stat i_stat,
    output bfs_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DEQ  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_QRES = 3'd4;
    localparam logic [2:0] S_DISP = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.action)
                    bfs_pkg::ACT_ENQ: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = bfs_pkg::ST_OVF;
                                o_cmd.out_dsel   = bfs_pkg::DSEL_ZERO;
                            end else begin
                                o_cmd.out_status = bfs_pkg::ST_ENQ;
                                o_cmd.out_dsel   = bfs_pkg::DSEL_VALUE;
                                o_cmd.enq_do     = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    bfs_pkg::ACT_DEQ: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = bfs_pkg::ST_UNF;
                                o_cmd.out_dsel   = bfs_pkg::DSEL_ZERO;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.deq_do = 1'b1;
                            n_state      = S_DEQ;
                        end
                    end
                    bfs_pkg::ACT_QUERY: begin
                        if (i_stat.empty) begin
                            n_state = S_QRES;
                        end else begin
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.walk_inc = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = bfs_pkg::ST_EMPTY;
                                o_cmd.out_dsel   = bfs_pkg::DSEL_ZERO;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.walk_inc = 1'b1;
                            n_state        = S_DISP;
                        end
                    end
                endcase
            end
            S_DEQ: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = bfs_pkg::ST_DEQ;
                    o_cmd.out_dsel   = bfs_pkg::DSEL_RDATA;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle, read the next one unless the walk has ended
                o_cmd.cmp_en = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = S_QRES;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_QRES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = i_stat.hit ? bfs_pkg::ST_FOUND : bfs_pkg::ST_NOTFOUND;
                    o_cmd.out_dsel   = bfs_pkg::DSEL_VALUE;
                    n_state          = S_IDLE;
                end
            end
            S_DISP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = i_stat.walk_end;
                    o_cmd.out_status = bfs_pkg::ST_ENTRY;
                    o_cmd.out_dsel   = bfs_pkg::DSEL_RDATA;
                    if (i_stat.walk_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.walk_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/bfs_dp.sv
// datapath of the bounded fifo with search block: ring store, pointers, result register
module bfs_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bfs_pkg::t_cmd                      i_cmd,
    output bfs_pkg::t_stat                     o_stat,
    input  bfs_pkg::t_action                   i_action,
    input  logic signed [bfs_pkg::DATA_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bfs_pkg::t_status                   o_out_status,
    output logic signed [bfs_pkg::DATA_W-1:0]  o_out_data,
    output logic                               o_out_last,
    input  logic                               i_cfg_we,
    input  logic [bfs_pkg::PADDR_W-1:0]        i_cfg_addr,
    input  logic [bfs_pkg::PDATA_W-1:0]        i_cfg_wdata,
    output logic [bfs_pkg::PDATA_W-1:0]        o_cfg_rdata
);

    logic [bfs_pkg::CAP_W-1:0]         r_cap;
    logic [bfs_pkg::IDX_W-1:0]         r_head;
    logic [bfs_pkg::CNT_W-1:0]         r_count;
    logic [bfs_pkg::CNT_W-1:0]         r_walk;
    bfs_pkg::t_action                  r_action;
    logic signed [bfs_pkg::DATA_W-1:0] r_value;
    logic                              r_hit;
    logic                              r_out_valid;
    bfs_pkg::t_status                  r_out_status;
    logic signed [bfs_pkg::DATA_W-1:0] r_out_data;
    logic                              r_out_last;

    logic [bfs_pkg::DATA_W-1:0]        w_rdata;
    logic [bfs_pkg::CMP_W-1:0]         w_eff_cap;
    logic [bfs_pkg::PADDR_W-3:0]       w_reg_idx;
    logic                              w_out_free;

    assign w_reg_idx  = i_cfg_addr[bfs_pkg::PADDR_W-1:2];
    assign w_out_free = !r_out_valid || i_out_ready;

    // capacity above the store depth saturates
    assign w_eff_cap = (bfs_pkg::CMP_W'(r_cap) > bfs_pkg::CMP_W'(bfs_pkg::DEPTH))
                       ? bfs_pkg::CMP_W'(bfs_pkg::DEPTH) : bfs_pkg::CMP_W'(r_cap);

    assign o_stat.action   = r_action;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (bfs_pkg::CMP_W'(r_count) >= w_eff_cap);
    assign o_stat.walk_end = (r_walk == r_count);
    assign o_stat.out_free = w_out_free;
    assign o_stat.hit      = r_hit;

    bfs_ram #(
        .WIDTH (bfs_pkg::DATA_W),
        .DEPTH (bfs_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq_do),
        .i_waddr (bfs_pkg::ring_pos(r_head, r_count)),
        .i_wdata (r_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (bfs_pkg::ring_pos(r_head, r_walk)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= bfs_pkg::CAP_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_walk      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (w_reg_idx == bfs_pkg::REG_CAPACITY)) begin
                r_cap <= i_cfg_wdata[bfs_pkg::CAP_W-1:0];
            end
            if (i_cmd.enq_do) begin
                r_count <= r_count + bfs_pkg::CNT_W'(1);
            end else if (i_cmd.deq_do) begin
                r_count <= r_count - bfs_pkg::CNT_W'(1);
                r_head  <= bfs_pkg::ring_pos(r_head, bfs_pkg::CNT_W'(1));
            end
            if (i_cmd.capture) begin
                r_walk <= '0;
                r_hit  <= 1'b0;
            end else begin
                if (i_cmd.walk_inc) begin
                    r_walk <= r_walk + bfs_pkg::CNT_W'(1);
                end
                if (i_cmd.cmp_en && (w_rdata == r_value)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
            case (i_cmd.out_dsel)
                bfs_pkg::DSEL_VALUE: r_out_data <= r_value;
                bfs_pkg::DSEL_RDATA: r_out_data <= w_rdata;
                default:             r_out_data <= '0;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

    assign o_cfg_rdata = (w_reg_idx == bfs_pkg::REG_CAPACITY)
                         ? bfs_pkg::PDATA_W'(r_cap) : '0;

endmodule
